// ----- sv/ist_pkg.sv -----
// Package with the shared constants and operation codes of the identifier set table.
`timescale 1ns / 1ps

package ist_pkg;

  // Fixed field widths of the request and response items.
  localparam int OP_W    = 2;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  // Operation codes carried in the op field.
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;
  localparam logic [OP_W-1:0] OP_GET  = 2'd3;

endpackage

// ----- sv/ist_if.sv -----
// Valid/ready channel interfaces for requests into and responses out of the table.
`timescale 1ns / 1ps

interface ist_req_if #(
  parameter int ID_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [ist_pkg::OP_W-1:0]     op;
  logic signed [ID_WIDTH-1:0]   id;
  logic [ist_pkg::INDEX_W-1:0]  index;

  modport source (output valid, output op, output id, output index, input ready);
  modport sink   (input valid, input op, input id, input index, output ready);
endinterface

interface ist_rsp_if #(
  parameter int ID_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic                         found;
  logic signed [ID_WIDTH-1:0]   element;
  logic [ist_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output found, output element,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input element,
                  input count, output ready);
endinterface

// ----- sv/id_set_table_unit.sv -----
// Top level of the identifier set table: a sequencer walking one memory port.
//
//   Channel  Direction  Handshake     Payload
//   req      in         valid/ready   op, id, index
//   rsp      out        valid/ready   status, found, element, count
//
// An item is taken only when the sequencer is idle. It then owns the block until
// its response has been loaded into the output register.
// A good get reads its entry through the read port; the no-id error and a get with a
// bad index go straight to the response. Add, delete and find walk the table one
// entry per cycle through the single registered read port until a hit or the end
// of the fill. A delete that hits then moves each later entry down one per cycle
// and then shrinks the table.
// Reset (rst, synchronous) empties the table; entry contents are not cleared.
// A stalled response holds in the output register; the next request is taken
// as soon as that response slot has been written.
`timescale 1ns / 1ps

module id_set_table_unit #(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  ist_req_if.sink    req,
  ist_rsp_if.source  rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > ist_pkg::INDEX_W) ? FW : ist_pkg::INDEX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_GET   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]               state;
  logic [ist_pkg::OP_W-1:0] op_q;
  logic [ID_WIDTH-1:0]      id_q;
  logic [FW-1:0]            fill;
  logic [FW-1:0]            ptr;

  logic                     res_status;
  logic                     res_found;
  logic [ID_WIDTH-1:0]      res_element;

  logic                     out_valid;
  logic                     out_status;
  logic                     out_found;
  logic [ID_WIDTH-1:0]      out_element;
  logic [ist_pkg::COUNT_W-1:0] out_count;

  logic [ID_WIDTH-1:0]      entries [CAPACITY];
  logic [ID_WIDTH-1:0]      rd_data;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ID_WIDTH-1:0]      mem_wdata;

  logic                     accept;
  logic                     out_free;
  logic                     no_id;
  logic                     index_ok;
  logic                     scan_end;
  logic                     scan_hit;
  logic                     shift_more;
  logic                     table_full;

  // Handshake and decision terms shared by the sequencer and the memory port.
  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign no_id      = (req.id == {ID_WIDTH{1'b1}});
  assign index_ok   = (CW'(req.index) < CW'(fill));
  assign scan_end   = (ptr >= fill);
  assign scan_hit   = (rd_data == id_q);
  assign shift_more = (ptr < fill);
  assign table_full = (fill == FW'(CAPACITY));

  // Memory port control: one read address and at most one write per cycle.
  always_comb begin
    rd_addr   = AW'(ptr + FW'(1));
    mem_we    = 1'b0;
    mem_waddr = AW'(fill);
    mem_wdata = id_q;
    unique case (state)
      S_IDLE: begin
        if (req.op == ist_pkg::OP_GET) begin
          rd_addr = AW'(req.index);
        end else begin
          rd_addr = '0;
        end
      end
      S_SCAN: begin
        if (scan_end && op_q == ist_pkg::OP_ADD && !table_full) begin
          mem_we = 1'b1;
        end
      end
      S_SHIFT: begin
        if (shift_more) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ptr - FW'(1));
          mem_wdata = rd_data;
        end
      end
      default: begin
        rd_addr = AW'(ptr);
      end
    endcase
  end

  // Table storage with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries[mem_waddr] <= mem_wdata;
    end
    rd_data <= entries[rd_addr];
  end

  // Operation sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q        <= req.op;
            id_q        <= req.id;
            ptr         <= '0;
            res_status  <= 1'b0;
            res_found   <= 1'b0;
            res_element <= '0;
            if (req.op == ist_pkg::OP_GET) begin
              if (index_ok) begin
                state <= S_GET;
              end else begin
                res_status  <= 1'b1;
                res_element <= {ID_WIDTH{1'b1}};
                state       <= S_RESP;
              end
            end else if (no_id) begin
              res_status <= 1'b1;
              state      <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            // Identifier is absent from the table.
            state <= S_RESP;
            unique case (op_q)
              ist_pkg::OP_ADD: begin
                if (table_full) begin
                  res_status <= 1'b1;
                end else begin
                  fill <= fill + FW'(1);
                end
              end
              ist_pkg::OP_DEL: res_status <= 1'b1;
              default: res_found <= 1'b0;
            endcase
          end else if (scan_hit) begin
            // Identifier found at position ptr.
            ptr <= ptr + FW'(1);
            if (op_q == ist_pkg::OP_DEL) begin
              state <= S_SHIFT;
            end else begin
              res_found <= (op_q == ist_pkg::OP_FIND);
              state     <= S_RESP;
            end
          end else begin
            ptr <= ptr + FW'(1);
          end
        end
        S_SHIFT: begin
          // Move each later entry down one place, then shrink the table.
          if (shift_more) begin
            ptr <= ptr + FW'(1);
          end else begin
            fill  <= fill - FW'(1);
            state <= S_RESP;
          end
        end
        S_GET: begin
          res_element <= rd_data;
          state       <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: loaded from the result when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      out_status  <= res_status;
      out_found   <= res_found;
      out_element <= res_element;
      out_count   <= ist_pkg::COUNT_W'(fill);
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.found   = out_found;
  assign rsp.element = out_element;
  assign rsp.count   = out_count;

endmodule

// ----- verif/id_set_table_unit_test.sv -----
// Self-checking testbench for the identifier set table: directed and random traffic.
`timescale 1ns / 1ps

module id_set_table_unit_test;

  localparam int DEPTH = 16;
  localparam int IDW = 32;
  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_TAIL = 100;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic signed [IDW-1:0] NO_ID = '1;
  localparam int OPW = ist_pkg::OP_W;
  localparam int IXW = ist_pkg::INDEX_W;
  localparam int CNTW = ist_pkg::COUNT_W;

  typedef struct packed {
    logic                   status;
    logic                   found;
    logic signed [IDW-1:0]  element;
    logic [CNTW-1:0]        count;
  } rsp_item_t;

  // Mirror of the table contents and the queue of responses it predicts.
  class id_table_tracker;
    logic signed [IDW-1:0] ids [DEPTH];
    int unsigned held;
    rsp_item_t pending [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned op_seen [4];
    int unsigned error_rsp;
    int unsigned full_hits;

    function new();
      held = 0;
      mismatches = 0;
      checked = 0;
      error_rsp = 0;
      full_hits = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int position_of(logic signed [IDW-1:0] id);
      for (int i = 0; i < held; i++) begin
        if (ids[i] == id) return i;
      end
      return -1;
    endfunction

    // Apply one accepted request to the mirror and queue its response.
    function void note_request(logic [OPW-1:0] op, logic signed [IDW-1:0] id,
                               logic [IXW-1:0] index);
      rsp_item_t want;
      int pos;
      want.status = 1'b0;
      want.found = 1'b0;
      want.element = '0;
      op_seen[op]++;
      if (op == ist_pkg::OP_GET) begin
        if (index < held) begin
          want.element = ids[index];
        end else begin
          want.status = 1'b1;
          want.element = NO_ID;
        end
      end else if (id == NO_ID) begin
        want.status = 1'b1;
      end else if (op == ist_pkg::OP_ADD) begin
        if (position_of(id) < 0) begin
          if (held >= DEPTH) begin
            want.status = 1'b1;
            full_hits++;
          end else begin
            ids[held] = id;
            held++;
          end
        end
      end else if (op == ist_pkg::OP_DEL) begin
        pos = position_of(id);
        if (pos < 0) begin
          want.status = 1'b1;
        end else begin
          for (int j = pos; j + 1 < held; j++) ids[j] = ids[j + 1];
          held--;
        end
      end else begin
        want.found = (position_of(id) >= 0);
      end
      want.count = CNTW'(held);
      if (want.status) error_rsp++;
      pending.push_back(want);
    endfunction

    // Compare one response transfer with the oldest prediction.
    function void check_response(logic status, logic found, logic signed [IDW-1:0] element,
                                 logic [CNTW-1:0] count);
      rsp_item_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] response with none expected: status=%0b found=%0b element=%h count=%0d",
                   $realtime, status, found, element, count);
        return;
      end
      want = pending.pop_front();
      if (status !== want.status || found !== want.found || element !== want.element ||
          count !== want.count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] response mismatch on transfer %0d", $realtime, checked);
          $display("  expected status=%0b found=%0b element=%h count=%0d",
                   want.status, want.found, want.element, want.count);
          $display("  actual   status=%0b found=%0b element=%h count=%0d",
                   status, found, element, count);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit idle_enable;
  int unsigned cycle_count;
  id_table_tracker tracker;

  ist_req_if #(.ID_WIDTH(IDW)) req_ch ();
  ist_rsp_if #(.ID_WIDTH(IDW)) rsp_ch ();

  id_set_table_unit #(
    .CAPACITY(DEPTH),
    .ID_WIDTH(IDW)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, tracker.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Response side: ready drops in random bursts while idling is enabled.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Check every response transfer.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_response(rsp_ch.status, rsp_ch.found, rsp_ch.element, rsp_ch.count);
  end

  // Present one request and hold it until the transfer; valid stays high afterwards.
  task automatic push_request(logic [OPW-1:0] op, logic signed [IDW-1:0] id,
                              logic [IXW-1:0] index);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op = op;
    req_ch.id = id;
    req_ch.index = index;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(op, id, index);
    @(negedge clk);
  endtask

  // Identifier mix: mostly held entries and small values, so that hits and misses both occur.
  function automatic logic signed [IDW-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45 && tracker.held > 0) return tracker.ids[$urandom_range(0, tracker.held - 1)];
    if (r < 50) return NO_ID;
    if (r < 65) return $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic logic [IXW-1:0] pick_index();
    if (tracker.held > 0 && $urandom_range(0, 1) == 0)
      return IXW'($urandom_range(0, tracker.held - 1));
    return IXW'($urandom_range(0, DEPTH - 1));
  endfunction

  // Directed corner cases: empty table, reserved id, duplicates, misses, full table, shifting.
  task automatic run_directed();
    push_request(ist_pkg::OP_GET, NO_ID, 4'd0);
    push_request(ist_pkg::OP_ADD, NO_ID, 4'd15);
    push_request(ist_pkg::OP_DEL, NO_ID, 4'd0);
    push_request(ist_pkg::OP_FIND, NO_ID, 4'd0);
    push_request(ist_pkg::OP_ADD, 32'sh7fffffff, 4'd0);
    push_request(ist_pkg::OP_ADD, 32'sh7fffffff, 4'd0);
    push_request(ist_pkg::OP_FIND, 32'sh7fffffff, 4'd0);
    push_request(ist_pkg::OP_FIND, 32'sh0, 4'd0);
    push_request(ist_pkg::OP_DEL, 32'sh0, 4'd0);
    push_request(ist_pkg::OP_ADD, 32'sh80000000, 4'd0);
    for (int i = 1; i <= DEPTH - 2; i++) push_request(ist_pkg::OP_ADD, i, 4'd0);
    push_request(ist_pkg::OP_ADD, 32'sh0, 4'd0);
    push_request(ist_pkg::OP_DEL, 32'sh7fffffff, 4'd0);
    push_request(ist_pkg::OP_GET, 32'sh0, 4'd0);
    push_request(ist_pkg::OP_GET, 32'sh7fffffff, 4'd15);
  endtask

  // Random traffic in phases: filling to full, draining, and mixed operations.
  task automatic run_random();
    int unsigned sent;
    int unsigned kind;
    int unsigned target;
    int unsigned burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent + QUIET_TAIL >= RANDOM_ITEMS) idle_enable = 1'b0;
      else idle_enable = ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        while (tracker.held < DEPTH) begin
          push_request(ist_pkg::OP_ADD, $urandom, IXW'($urandom_range(0, DEPTH - 1)));
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          push_request(ist_pkg::OP_ADD, $urandom, IXW'($urandom_range(0, DEPTH - 1)));
          sent++;
        end
      end else if (kind < 5) begin
        target = $urandom_range(0, tracker.held);
        while (tracker.held > target) begin
          if ($urandom_range(0, 7) == 0)
            push_request(ist_pkg::OP_DEL, $urandom, IXW'($urandom_range(0, DEPTH - 1)));
          else
            push_request(ist_pkg::OP_DEL, tracker.ids[$urandom_range(0, tracker.held - 1)],
                         IXW'($urandom_range(0, DEPTH - 1)));
          sent++;
        end
      end else begin
        burst = $urandom_range(10, 30);
        repeat (burst) begin
          push_request(OPW'($urandom_range(0, 3)), pick_id(), pick_index());
          sent++;
        end
      end
    end
  endtask

  // Main sequence: reset, directed part, random part, drain, verdict.
  initial begin
    int unsigned fails;
    tracker = new();
    cycle_count = 0;
    idle_enable = 1'b1;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = ist_pkg::OP_ADD;
    req_ch.id = '0;
    req_ch.index = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    run_directed();
    run_random();
    req_ch.valid = 1'b0;
    while (tracker.pending.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fails = tracker.mismatches + tracker.pending.size();
    $display("Covered %0d adds, %0d deletes, %0d finds and %0d gets; %0d responses checked.",
             tracker.op_seen[ist_pkg::OP_ADD], tracker.op_seen[ist_pkg::OP_DEL],
             tracker.op_seen[ist_pkg::OP_FIND], tracker.op_seen[ist_pkg::OP_GET],
             tracker.checked);
    $display("%0d responses carried an error status, %0d of them adds to a full table; %0d bad.",
             tracker.error_rsp, tracker.full_hits, fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
